### rtl/gda_pkg.sv
`timescale 1ns / 1ps

package gda_pkg;

  localparam int MAX_YEAR   = 9999;
  localparam int DIFF_LIMIT = 4194303;

  // last day number of MAX_YEAR, counted from 0000-01-01
  localparam int LAST_DAY = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 1 + 3) / 4
                          - (MAX_YEAR + 1 + 99) / 100 + (MAX_YEAR + 1 + 399) / 400 - 1;

  // ceil(2^32 * 400 / 146097), day number to year estimate
  localparam longint YEAR_RECIP = ((64'd1 << 32) * 400 + 146096) / 146097;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_CMP = 2'd2;

  localparam logic [1:0] ORDER_LESS    = 2'd0;
  localparam logic [1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [1:0] ORDER_GREATER = 2'd2;

  // x / 100 for x below 2^15
  function automatic logic [8:0] div100(input logic [14:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd20972;
    return p[29:21];
  endfunction

  // x / 400 for x below 2^15
  function automatic logic [6:0] div400(input logic [14:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd20972;
    return p[29:23];
  endfunction

  function automatic logic is_leap(input logic [14:0] y);
    logic [8:0] q1;
    logic [6:0] q4;
    q1 = div100(y);
    q4 = div400(y);
    return (y[1:0] == 2'd0) &&
           ((15'(q1) * 15'd100 != y) || (15'(q4) * 15'd400 == y));
  endfunction

  // days before the first of year y, from precomputed quotients
  function automatic logic [23:0] dby_q(input logic [14:0] y, input logic [8:0] q1,
                                        input logic [6:0] q4);
    logic [14:0] y3;
    y3 = y + 15'd3;
    return 24'(y) * 24'd365 + 24'(y3[14:2]) - 24'(q1) + 24'(q4);
  endfunction

  // days before the first of month m (1..12)
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && m > 4'd2) c = c + 9'd1;
    return c;
  endfunction

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    if (m == 4'd0) return 4'd1;
    if (m > 4'd12) return 4'd12;
    return m;
  endfunction

endpackage

### rtl/gregorian_date_arithmetic.sv
`timescale 1ns / 1ps

// Gregorian date unit, eight register stages deep. A beat is taken on every cycle that
// start_i is high (busy_o is always low), and its result appears on done_o once it has
// passed all stages, one result per cycle sustained. The depth is set by the day number to date
// conversion: year estimate multiply, candidate year quotients, year pick, leap test and
// month search each hold a stage. The receiver cannot stall; results are never held.
module gregorian_date_arithmetic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [13:0] year_a_i,
  input  logic [3:0]  month_a_i,
  input  logic [4:0]  day_a_i,
  input  logic [13:0] year_b_i,
  input  logic [3:0]  month_b_i,
  input  logic [4:0]  day_b_i,
  input  logic signed [22:0] day_offset_i,
  output logic        done_o,
  output logic [13:0] result_year_o,
  output logic [3:0]  result_month_o,
  output logic [4:0]  result_day_o,
  output logic [1:0]  order_o,
  output logic signed [22:0] day_difference_o,
  output logic        out_of_range_o
);

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  order;
    logic [22:0] diff;
    logic        oor;
  } side_t;

  logic [7:0] v_q;

  // stage 1: year quotients and leap of both dates
  logic [1:0]  s1_mode_q;
  logic [14:0] s1_ya_q, s1_yb_q;
  logic [8:0]  s1_qa1_q, s1_qb1_q;
  logic [6:0]  s1_qa4_q, s1_qb4_q;
  logic        s1_la_q, s1_lb_q;
  logic [3:0]  s1_ma_q, s1_mb_q;
  logic [4:0]  s1_da_q, s1_db_q;
  logic signed [22:0] s1_off_q;

  // stage 2: day numbers
  logic [1:0]  s2_mode_q;
  logic signed [24:0] s2_na_q, s2_nb_q;
  logic signed [22:0] s2_off_q;

  // stage 3: operation and saturation
  side_t       s3_side_q, s3_side_d;
  logic [21:0] s3_n_q, s3_n_d;

  // stage 4: year estimate
  side_t       s4_side_q;
  logic [21:0] s4_n_q;
  logic [14:0] s4_y0_q;

  // stage 5: candidate quotients
  side_t       s5_side_q;
  logic [21:0] s5_n_q;
  logic [14:0] s5_y0_q;
  logic [8:0]  s5_q1_q [3];
  logic [6:0]  s5_q4_q [3];

  // stage 6: year and remainder
  side_t       s6_side_q;
  logic [14:0] s6_y_q, s6_y_d;
  logic [8:0]  s6_rem_q, s6_rem_d;

  // stage 7: leap of result year
  side_t       s7_side_q;
  logic [14:0] s7_y_q;
  logic [8:0]  s7_rem_q;
  logic        s7_leap_q;

  logic [3:0]  s8_m;
  logic [8:0]  s8_day;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:0], start_i};
    end
  end
  assign done_o = v_q[7];

  always_ff @(posedge clk_i) begin
    s1_mode_q <= mode_i;
    s1_ya_q   <= 15'(year_a_i);
    s1_yb_q   <= 15'(year_b_i);
    s1_qa1_q  <= gda_pkg::div100(15'(year_a_i) + 15'd99);
    s1_qb1_q  <= gda_pkg::div100(15'(year_b_i) + 15'd99);
    s1_qa4_q  <= gda_pkg::div400(15'(year_a_i) + 15'd399);
    s1_qb4_q  <= gda_pkg::div400(15'(year_b_i) + 15'd399);
    s1_la_q   <= gda_pkg::is_leap(15'(year_a_i));
    s1_lb_q   <= gda_pkg::is_leap(15'(year_b_i));
    s1_ma_q   <= gda_pkg::clamp_month(month_a_i);
    s1_mb_q   <= gda_pkg::clamp_month(month_b_i);
    s1_da_q   <= day_a_i;
    s1_db_q   <= day_b_i;
    s1_off_q  <= day_offset_i;
  end

  always_ff @(posedge clk_i) begin
    s2_mode_q <= s1_mode_q;
    s2_off_q  <= s1_off_q;
    s2_na_q   <= $signed({1'b0, gda_pkg::dby_q(s1_ya_q, s1_qa1_q, s1_qa4_q)})
               + $signed({16'd0, gda_pkg::cum_days(s1_ma_q, s1_la_q)})
               + $signed({20'd0, s1_da_q}) - 25'sd1;
    s2_nb_q   <= $signed({1'b0, gda_pkg::dby_q(s1_yb_q, s1_qb1_q, s1_qb4_q)})
               + $signed({16'd0, gda_pkg::cum_days(s1_mb_q, s1_lb_q)})
               + $signed({20'd0, s1_db_q}) - 25'sd1;
  end

  always_comb begin
    logic signed [25:0] r;
    s3_side_d      = '0;
    s3_side_d.mode = s2_mode_q;
    s3_n_d         = '0;
    case (s2_mode_q)
      gda_pkg::MODE_ADD, gda_pkg::MODE_SUB: begin
        if (s2_mode_q == gda_pkg::MODE_ADD) r = 26'(s2_na_q) + 26'(s2_off_q);
        else                                 r = 26'(s2_na_q) - 26'(s2_off_q);
        if (r < 0) begin
          s3_side_d.oor = 1'b1;
        end else if (r > 26'(gda_pkg::LAST_DAY)) begin
          s3_n_d        = 22'(gda_pkg::LAST_DAY);
          s3_side_d.oor = 1'b1;
        end else begin
          s3_n_d = r[21:0];
        end
      end
      gda_pkg::MODE_CMP: begin
        r = 26'(s2_na_q) - 26'(s2_nb_q);
        if (r < 0)       s3_side_d.order = gda_pkg::ORDER_LESS;
        else if (r == 0) s3_side_d.order = gda_pkg::ORDER_EQUAL;
        else             s3_side_d.order = gda_pkg::ORDER_GREATER;
        if (r > 26'(gda_pkg::DIFF_LIMIT)) begin
          s3_side_d.diff = 23'(gda_pkg::DIFF_LIMIT);
          s3_side_d.oor  = 1'b1;
        end else if (r < -26'(gda_pkg::DIFF_LIMIT)) begin
          s3_side_d.diff = -23'(gda_pkg::DIFF_LIMIT);
          s3_side_d.oor  = 1'b1;
        end else begin
          s3_side_d.diff = r[22:0];
        end
      end
      default: r = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    s3_side_q <= s3_side_d;
    s3_n_q    <= s3_n_d;
  end

  always_ff @(posedge clk_i) begin
    logic [55:0] p;
    p = 56'(s3_n_q) * 56'(gda_pkg::YEAR_RECIP);
    s4_side_q <= s3_side_q;
    s4_n_q    <= s3_n_q;
    s4_y0_q   <= p[46:32];
  end

  // candidates y0-1, y0, y0+1; the estimate is within one year
  always_ff @(posedge clk_i) begin
    logic [14:0] yc;
    s5_side_q <= s4_side_q;
    s5_n_q    <= s4_n_q;
    s5_y0_q   <= s4_y0_q;
    for (int c = 0; c < 3; c++) begin
      yc = s4_y0_q + 15'(c) - 15'd1;
      s5_q1_q[c] <= gda_pkg::div100(yc + 15'd99);
      s5_q4_q[c] <= gda_pkg::div400(yc + 15'd399);
    end
  end

  always_comb begin
    logic [23:0] d1, d2, d0, ds;
    d0 = gda_pkg::dby_q(s5_y0_q - 15'd1, s5_q1_q[0], s5_q4_q[0]);
    d1 = gda_pkg::dby_q(s5_y0_q, s5_q1_q[1], s5_q4_q[1]);
    d2 = gda_pkg::dby_q(s5_y0_q + 15'd1, s5_q1_q[2], s5_q4_q[2]);
    if (d2 <= 24'(s5_n_q)) begin
      s6_y_d = s5_y0_q + 15'd1;
      ds     = d2;
    end else if (d1 <= 24'(s5_n_q) || s5_y0_q == 15'd0) begin
      s6_y_d = s5_y0_q;
      ds     = d1;
    end else begin
      s6_y_d = s5_y0_q - 15'd1;
      ds     = d0;
    end
    s6_rem_d = 9'(24'(s5_n_q) - ds);
  end

  always_ff @(posedge clk_i) begin
    s6_side_q <= s5_side_q;
    s6_y_q    <= s6_y_d;
    s6_rem_q  <= s6_rem_d;
  end

  always_ff @(posedge clk_i) begin
    s7_side_q <= s6_side_q;
    s7_y_q    <= s6_y_q;
    s7_rem_q  <= s6_rem_q;
    s7_leap_q <= gda_pkg::is_leap(s6_y_q);
  end

  // month search: last month whose first day is not past the remainder
  always_comb begin
    s8_m = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (s7_rem_q >= gda_pkg::cum_days(4'(k), s7_leap_q)) s8_m = 4'(k);
    end
    s8_day = s7_rem_q - gda_pkg::cum_days(s8_m, s7_leap_q) + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    order_o          <= s7_side_q.order;
    day_difference_o <= s7_side_q.diff;
    out_of_range_o   <= s7_side_q.oor;
    if (s7_side_q.mode == gda_pkg::MODE_ADD || s7_side_q.mode == gda_pkg::MODE_SUB) begin
      result_year_o  <= s7_y_q[13:0];
      result_month_o <= s8_m;
      result_day_o   <= s8_day[4:0];
    end else begin
      result_year_o  <= '0;
      result_month_o <= '0;
      result_day_o   <= '0;
    end
  end

endmodule
